@@ rtl/bthalloc_pkg.sv @@
// ----------------------------------------------------------------------------
// bthalloc_pkg
// Shared constants of the block table heap allocator.
// ----------------------------------------------------------------------------
package bthalloc_pkg;

  // Byte accumulators hold up to table depth times block size.
  localparam int BYTE_W = 33;

  // Flag bits of one table entry.
  localparam int FLAG_W     = 3;
  localparam int FLAG_TAKEN = 0;
  localparam int FLAG_FIRST = 1;
  localparam int FLAG_NEXT  = 2;

  // Request kinds carried in tuser.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // Register select bit of paddr: 0 heap_base, 1 block_count.
  localparam logic REG_HEAP_BASE   = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  localparam logic [31:0] HEAP_BASE_RESET   = 32'd0;
  localparam logic [10:0] BLOCK_COUNT_RESET = 11'd1024;

endpackage

@@ rtl/block_table_heap_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// block_table_heap_allocator_unit
// First-fit allocator over a table of fixed-size heap blocks.
// ----------------------------------------------------------------------------
// The heap is a row of BLOCK_BYTES-byte blocks starting at heap_base, with one
// three-bit table entry per block held in a single-port-read memory. After
// reset a clearing pass writes every one of the TABLE_BLOCKS entries, one per
// cycle, before the first request is accepted. An allocate beat walks the
// table one entry per cycle looking for the first long enough run of free
// blocks, then marks the run one entry per cycle. A free beat first finds the
// block index by stepping a byte offset one block per cycle, then clears the
// run one entry per cycle from that index; the two walks together cover at
// most the blocks in use. The table walk is paced by the one memory read per
// cycle. One request is worked on at a time; a finished result waits in the
// output register while the next request is taken.
// ----------------------------------------------------------------------------
module block_table_heap_allocator_unit #(
  parameter int TABLE_BLOCKS = 1024,
  parameter int BLOCK_BYTES  = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // Request stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] size_bytes, [63:32] address
  input  logic [0:0]  s_tuser,   // [0] action
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [1:0] status, [33:2] block_address, rest zero
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = $clog2(TABLE_BLOCKS);
  localparam int CNT_W = $clog2(TABLE_BLOCKS + 1);
  localparam int BW    = bthalloc_pkg::BYTE_W;
  localparam int FW    = bthalloc_pkg::FLAG_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_SCAN,
    S_ALLOC_MARK,
    S_FREE_FIND,
    S_FREE_CLR,
    S_RESP
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0] cur, cur_next;
  logic [BW-1:0]    acc, acc_next;
  logic [BW-1:0]    run_bytes, run_bytes_next;
  logic [IDX_W-1:0] start_idx, start_idx_next;
  logic [31:0]      start_bytes, start_bytes_next;
  logic [31:0]      req_size, req_size_next;
  logic [31:0]      req_off, req_off_next;
  logic [1:0]       res_status, res_status_next;
  logic [31:0]      res_addr, res_addr_next;
  logic             m_tvalid_next;
  logic [1:0]       out_status, out_status_next;
  logic [31:0]      out_addr, out_addr_next;

  logic [31:0]      heap_base;
  logic [10:0]      block_count;
  logic [CNT_W-1:0] lim;

  logic [FW-1:0]    mem [TABLE_BLOCKS];
  logic [FW-1:0]    rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [FW-1:0]    mem_wdata;

  logic [BW-1:0]    acc_step;
  logic [BW-1:0]    run_step;
  logic             out_free;
  logic             cfg_wr;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == bthalloc_pkg::REG_BLOCK_COUNT) ? 32'(block_count) : heap_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base   <= bthalloc_pkg::HEAP_BASE_RESET;
      block_count <= bthalloc_pkg::BLOCK_COUNT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == bthalloc_pkg::REG_BLOCK_COUNT) begin
        block_count <= pwdata[10:0];
      end else begin
        heap_base <= pwdata;
      end
    end
  end

  // A block count beyond the table depth acts as the table depth.
  assign lim = (32'(block_count) > 32'(TABLE_BLOCKS)) ? CNT_W'(TABLE_BLOCKS)
                                                       : CNT_W'(block_count);

  // Block table. The read address is the next walk position, so the entry
  // at cur is on rd_data whilst a walk state looks at it.
  assign rd_addr = cur_next[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur[IDX_W-1:0]] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  assign acc_step = acc + BW'(BLOCK_BYTES);
  assign run_step = run_bytes + BW'(BLOCK_BYTES);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next       = state;
    cur_next         = cur;
    acc_next         = acc;
    run_bytes_next   = run_bytes;
    start_idx_next   = start_idx;
    start_bytes_next = start_bytes;
    req_size_next    = req_size;
    req_off_next     = req_off;
    res_status_next  = res_status;
    res_addr_next    = res_addr;
    m_tvalid_next    = m_tvalid && !m_tready;
    out_status_next  = out_status;
    out_addr_next    = out_addr;
    mem_we           = 1'b0;
    mem_wdata        = '0;

    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (cur == CNT_W'(TABLE_BLOCKS - 1)) begin
          cur_next   = '0;
          state_next = S_IDLE;
        end else begin
          cur_next = cur + CNT_W'(1);
        end
      end

      S_IDLE: begin
        if (s_tvalid) begin
          cur_next       = '0;
          acc_next       = '0;
          run_bytes_next = '0;
          res_addr_next  = '0;
          req_size_next  = s_tdata[31:0];
          req_off_next   = s_tdata[63:32] - heap_base;
          if (s_tuser[0] == bthalloc_pkg::ACT_FREE) begin
            if (s_tdata[63:32] < heap_base) begin
              res_status_next = bthalloc_pkg::ST_BAD;
              state_next      = S_RESP;
            end else begin
              state_next = S_FREE_FIND;
            end
          end else begin
            if (s_tdata[31:0] == 32'd0) begin
              res_status_next = bthalloc_pkg::ST_BAD;
              state_next      = S_RESP;
            end else begin
              state_next = S_ALLOC_SCAN;
            end
          end
        end
      end

      S_ALLOC_SCAN: begin
        if (cur == lim) begin
          res_status_next = bthalloc_pkg::ST_NOMEM;
          state_next      = S_RESP;
        end else if (rd_data[bthalloc_pkg::FLAG_TAKEN]) begin
          run_bytes_next = '0;
          cur_next       = cur + CNT_W'(1);
          acc_next       = acc_step;
        end else begin
          if (run_bytes == '0) begin
            start_idx_next   = cur[IDX_W-1:0];
            start_bytes_next = acc[31:0];
          end
          if (run_step >= BW'(req_size)) begin
            // Run is long enough: go back to its first block and mark it.
            cur_next       = (run_bytes == '0) ? cur : CNT_W'(start_idx);
            run_bytes_next = '0;
            state_next     = S_ALLOC_MARK;
          end else begin
            run_bytes_next = run_step;
            cur_next       = cur + CNT_W'(1);
            acc_next       = acc_step;
          end
        end
      end

      S_ALLOC_MARK: begin
        mem_we = 1'b1;
        mem_wdata[bthalloc_pkg::FLAG_TAKEN] = 1'b1;
        mem_wdata[bthalloc_pkg::FLAG_FIRST] = (run_bytes == '0);
        mem_wdata[bthalloc_pkg::FLAG_NEXT]  = (run_step < BW'(req_size));
        if (run_step >= BW'(req_size)) begin
          res_status_next = bthalloc_pkg::ST_OK;
          res_addr_next   = heap_base + start_bytes;
          state_next      = S_RESP;
        end else begin
          run_bytes_next = run_step;
          cur_next       = cur + CNT_W'(1);
        end
      end

      S_FREE_FIND: begin
        // The index is the first block whose end lies beyond the offset.
        if (cur == lim) begin
          res_status_next = bthalloc_pkg::ST_BAD;
          state_next      = S_RESP;
        end else if (BW'(req_off) < acc_step) begin
          state_next = S_FREE_CLR;
        end else begin
          cur_next = cur + CNT_W'(1);
          acc_next = acc_step;
        end
      end

      S_FREE_CLR: begin
        mem_we = 1'b1;
        if (!rd_data[bthalloc_pkg::FLAG_NEXT] || ((cur + CNT_W'(1)) == lim)) begin
          res_status_next = bthalloc_pkg::ST_OK;
          state_next      = S_RESP;
        end else begin
          cur_next = cur + CNT_W'(1);
        end
      end

      S_RESP: begin
        if (out_free) begin
          m_tvalid_next   = 1'b1;
          out_status_next = res_status;
          out_addr_next   = res_addr;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cur      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cur      <= cur_next;
      m_tvalid <= m_tvalid_next;
    end
    acc         <= acc_next;
    run_bytes   <= run_bytes_next;
    start_idx   <= start_idx_next;
    start_bytes <= start_bytes_next;
    req_size    <= req_size_next;
    req_off     <= req_off_next;
    res_status  <= res_status_next;
    res_addr    <= res_addr_next;
    out_status  <= out_status_next;
    out_addr    <= out_addr_next;
  end

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {6'd0, out_addr, out_status};

`ifndef SYNTHESIS
  a_no_req_in_clear : assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready)
    else $error("request taken during the table clearing pass");

  a_status_code : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == bthalloc_pkg::ST_OK ||
                  m_tdata[1:0] == bthalloc_pkg::ST_NOMEM ||
                  m_tdata[1:0] == bthalloc_pkg::ST_BAD))
    else $error("result carries an undefined status code");

  a_fail_zero_addr : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[1:0] != bthalloc_pkg::ST_OK)) |-> (m_tdata[33:2] == 32'd0))
    else $error("failed request returned a non-zero address");

  a_walk_in_range : assert property (@(posedge clk) disable iff (rst)
    (state == S_ALLOC_SCAN || state == S_FREE_FIND) |-> (cur <= lim))
    else $error("table walk ran past the block count");

  a_clr_in_range : assert property (@(posedge clk) disable iff (rst)
    (state == S_ALLOC_MARK || state == S_FREE_CLR) |-> (cur < lim))
    else $error("table write outside the blocks in use");
`endif

endmodule
